// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the filter core.
// Each macro expands to one labeled concurrent assertion clocked by clk
// and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every checked clock edge.
`define PKVF_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true at a checked clock edge.
`define PKVF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/pkvf_pkg.sv -----
// ----------------------------------------------------------------------------
// pkvf_pkg
// Shared constants, types and the micro-op table of the peak versus variance
// filter.
// ----------------------------------------------------------------------------
package pkvf_pkg;

  // Capacity limits.
  localparam int MAX_SESSIONS = 16384;
  localparam int MAX_USERS    = 2048;

  // Widths that follow from the limits and the 32-bit fields.
  localparam int ADDR_W = $clog2(MAX_USERS);
  localparam int UCNT_W = $clog2(MAX_USERS + 1);
  localparam int SCNT_W = $clog2(MAX_SESSIONS + 1);
  localparam int WORD_W = 32;
  localparam int PROD_W = 64;
  localparam int SUM_W  = 48;
  localparam int SQ_W   = 80;
  localparam int ACC_W  = 96;

  // Operation codes of a request.
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Status codes of a result.
  localparam logic [2:0] STAT_ACCEPTED       = 3'd0;
  localparam logic [2:0] STAT_REPORTED       = 3'd1;
  localparam logic [2:0] STAT_NO_MORE        = 3'd2;
  localparam logic [2:0] STAT_TOO_MANY_SESS  = 3'd3;
  localparam logic [2:0] STAT_TOO_MANY_USERS = 3'd4;

  typedef enum logic [1:0] {
    FAULT_NONE,
    FAULT_SESSIONS,
    FAULT_USERS
  } fault_t;

  // Accumulator operations of the shared multiply unit.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  // Operand sources for the multiplier.
  typedef enum logic [3:0] {
    SRC_DUR,
    SRC_CNT,
    SRC_SQ0,
    SRC_SQ1,
    SRC_SQ2,
    SRC_S0,
    SRC_S1,
    SRC_PEAK,
    SRC_P2LO,
    SRC_P2HI,
    SRC_N2
  } src_t;

  typedef struct packed {
    src_t       src_a;
    src_t       src_b;
    logic [1:0] shift;
    acc_op_t    acc_op;
  } uop_t;

  // Control bundle toward the multiply-accumulate unit.
  typedef struct packed {
    logic              mul_en;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [1:0]        shift;
    acc_op_t           acc_op;
  } mac_ctrl_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_MUL,
    S_ACC,
    S_NEW_WR,
    S_PK_RD,
    S_PK_CMP,
    S_RHS,
    S_SCAN_RD,
    S_SCAN_LAT,
    S_CMP,
    S_DONE
  } state_t;

  // Micro-op indexes with a special meaning.
  localparam logic [3:0] STEP_SQUARE   = 4'd0;
  localparam logic [3:0] STEP_N2       = 4'd1;
  localparam logic [3:0] STEP_RHS_LAST = 4'd8;
  localparam logic [3:0] STEP_P2       = 4'd9;
  localparam logic [3:0] STEP_LHS_LAST = 4'd11;

  // Micro-op table. Step 0 squares a duration. Steps 1 to 8 form n^2 and
  // n*sumsq - sum^2. Steps 9 to 11 form peak^2 * n^2.
  function automatic uop_t uop_rom(input logic [3:0] idx);
    uop_t u;
    unique case (idx)
      4'd0:    u = '{SRC_DUR,  SRC_DUR,  2'd0, ACC_HOLD};
      4'd1:    u = '{SRC_CNT,  SRC_CNT,  2'd0, ACC_HOLD};
      4'd2:    u = '{SRC_SQ0,  SRC_CNT,  2'd0, ACC_LOAD};
      4'd3:    u = '{SRC_SQ1,  SRC_CNT,  2'd1, ACC_ADD};
      4'd4:    u = '{SRC_SQ2,  SRC_CNT,  2'd2, ACC_ADD};
      4'd5:    u = '{SRC_S0,   SRC_S0,   2'd0, ACC_SUB};
      4'd6:    u = '{SRC_S0,   SRC_S1,   2'd1, ACC_SUB};
      4'd7:    u = '{SRC_S0,   SRC_S1,   2'd1, ACC_SUB};
      4'd8:    u = '{SRC_S1,   SRC_S1,   2'd2, ACC_SUB};
      4'd9:    u = '{SRC_PEAK, SRC_PEAK, 2'd0, ACC_HOLD};
      4'd10:   u = '{SRC_P2LO, SRC_N2,   2'd0, ACC_LOAD};
      4'd11:   u = '{SRC_P2HI, SRC_N2,   2'd1, ACC_ADD};
      default: u = '{SRC_DUR,  SRC_DUR,  2'd0, ACC_HOLD};
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/pkvf_ram.sv -----
// ----------------------------------------------------------------------------
// pkvf_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pkvf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request; the read data is registered and returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/pkvf_mac.sv -----
// ----------------------------------------------------------------------------
// pkvf_mac
// Shared 32x32 multiplier with a registered product and a 96-bit
// accumulator that loads, adds or subtracts the product at a word offset.
// ----------------------------------------------------------------------------
module pkvf_mac (
  input  logic                          clk,
  input  pkvf_pkg::mac_ctrl_t           ctrl,
  output logic [pkvf_pkg::PROD_W-1:0]   prod,
  output logic [pkvf_pkg::ACC_W-1:0]    acc
);
  import pkvf_pkg::*;

  logic [1:0]       shift_q;
  logic [ACC_W-1:0] addend;

  // Register the product together with its word offset.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod    <= ctrl.a * ctrl.b;
      shift_q <= ctrl.shift;
    end
  end

  // Place the product at its word offset.
  always_comb begin
    case (shift_q)
      2'd1:    addend = {prod, {WORD_W{1'b0}}};
      2'd2:    addend = {prod[WORD_W-1:0], {PROD_W{1'b0}}};
      default: addend = {{WORD_W{1'b0}}, prod};
    endcase
  end

  // Accumulate.
  always_ff @(posedge clk) begin
    case (ctrl.acc_op)
      ACC_LOAD: acc <= addend;
      ACC_ADD:  acc <= acc + addend;
      ACC_SUB:  acc <= acc - addend;
      default:  acc <= acc;
    endcase
  end

endmodule

// ----- rtl/per_key_max_vs_variance_filter_core.sv -----
// Add request: linear search of the user table, one entry a cycle, then
// one squaring on the shared multiplier and the table update.
// Fetch request: forms n^2 and n*sumsq - sum^2 on the shared multiplier,
// then scans the user entries one at a time and delivers the result.
// One request is in work at a time; a result waits in the output register.
// Reset (synchronous, rst high) clears counts, totals, cursor and fault.
// ----------------------------------------------------------------------------
// per_key_max_vs_variance_filter_core
// Keeps session totals and a per-user peak table, and reports users whose
// squared peak exceeds the population variance, tested exactly in integers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module per_key_max_vs_variance_filter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic        first_of_set,
  input  logic [31:0] user_id,
  input  logic [31:0] start_time,
  input  logic [31:0] end_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] report_user,
  output logic [31:0] max_duration
);
  import pkvf_pkg::*;

  state_t state, state_next;

  logic [UCNT_W-1:0] key_count;
  logic [SCNT_W-1:0] record_count;
  logic [SUM_W-1:0]  length_total;
  logic [SQ_W-1:0]   square_total;
  logic [UCNT_W-1:0] report_cursor;
  fault_t            fault;

  logic              op_q;
  logic [31:0]       uid_q;
  logic [31:0]       dur_q;
  logic [UCNT_W-1:0] srch_idx;
  logic              cmp_valid;
  logic [UCNT_W-1:0] cmp_idx;
  logic [UCNT_W-1:0] slot;
  logic              is_new;
  logic [3:0]        step;
  logic [31:0]       n2;
  logic [PROD_W-1:0] p2;
  logic [ACC_W-1:0]  rhs;
  logic [31:0]       cand_key;
  logic [31:0]       cand_peak;
  logic [2:0]        res_status;
  logic [31:0]       res_user;
  logic [31:0]       res_peak;

  logic              in_accept;
  logic              do_clear;
  fault_t            fault_eff;
  logic              rec_full;
  logic              srch_hit;
  logic              srch_more;
  logic              lhs_wins;
  logic              scan_last;
  logic              out_free;
  uop_t              uop;

  mac_ctrl_t         mac_ctrl;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc;

  logic              ram_we_key;
  logic              ram_we_peak;
  logic [ADDR_W-1:0] ram_addr;
  logic [31:0]       key_rdata;
  logic [31:0]       peak_rdata;

  // Fault code to result status.
  function automatic logic [2:0] fault_status(input fault_t f);
    logic [2:0] s;
    case (f)
      FAULT_SESSIONS: s = STAT_TOO_MANY_SESS;
      default:        s = STAT_TOO_MANY_USERS;
    endcase
    return s;
  endfunction

  // Operand selection for the shared multiplier.
  function automatic logic [31:0] pick(input src_t src, input logic [31:0] dur,
                                       input logic [SCNT_W-1:0] cnt,
                                       input logic [SQ_W-1:0] sq,
                                       input logic [SUM_W-1:0] sum,
                                       input logic [31:0] peak,
                                       input logic [PROD_W-1:0] pp,
                                       input logic [31:0] nn);
    logic [31:0] v;
    case (src)
      SRC_DUR:  v = dur;
      SRC_CNT:  v = 32'(cnt);
      SRC_SQ0:  v = sq[31:0];
      SRC_SQ1:  v = sq[63:32];
      SRC_SQ2:  v = 32'(sq[SQ_W-1:64]);
      SRC_S0:   v = sum[31:0];
      SRC_S1:   v = 32'(sum[SUM_W-1:32]);
      SRC_PEAK: v = peak;
      SRC_P2LO: v = pp[31:0];
      SRC_P2HI: v = pp[63:32];
      SRC_N2:   v = nn;
      default:  v = '0;
    endcase
    return v;
  endfunction

  // Shared multiply-accumulate unit and the two user tables.
  pkvf_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .prod (prod),
    .acc  (acc)
  );

  pkvf_ram #(.WIDTH(32), .DEPTH(MAX_USERS)) u_key_ram (
    .clk   (clk),
    .we    (ram_we_key),
    .addr  (ram_addr),
    .wdata (uid_q),
    .rdata (key_rdata)
  );

  pkvf_ram #(.WIDTH(32), .DEPTH(MAX_USERS)) u_peak_ram (
    .clk   (clk),
    .we    (ram_we_peak),
    .addr  (ram_addr),
    .wdata (dur_q),
    .rdata (peak_rdata)
  );

  // Decision terms used by the sequencer.
  assign in_accept = in_valid && !in_stall;
  assign do_clear  = (operation == OP_ADD) && first_of_set;
  assign fault_eff = do_clear ? FAULT_NONE : fault;
  assign rec_full  = !do_clear && (record_count == SCNT_W'(MAX_SESSIONS));
  assign srch_hit  = cmp_valid && (key_rdata == uid_q);
  assign srch_more = srch_idx < key_count;
  assign lhs_wins  = acc > rhs;
  assign scan_last = (report_cursor + 1'b1) == key_count;
  assign out_free  = !out_valid || !out_stall;
  assign uop       = uop_rom(step);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (fault_eff != FAULT_NONE) begin
            state_next = S_DONE;
          end else if (operation == OP_ADD) begin
            state_next = rec_full ? S_DONE : S_SRCH;
          end else if (report_cursor >= key_count) begin
            state_next = S_DONE;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_SRCH: begin
        if (srch_hit) begin
          state_next = S_MUL;
        end else if (!srch_more) begin
          state_next = (key_count == UCNT_W'(MAX_USERS)) ? S_DONE : S_MUL;
        end
      end
      S_MUL: state_next = S_ACC;
      S_ACC: begin
        if (step == STEP_SQUARE) begin
          state_next = is_new ? S_NEW_WR : S_PK_RD;
        end else if (step == STEP_RHS_LAST) begin
          state_next = S_RHS;
        end else if (step == STEP_LHS_LAST) begin
          state_next = S_CMP;
        end else begin
          state_next = S_MUL;
        end
      end
      S_NEW_WR:   state_next = S_DONE;
      S_PK_RD:    state_next = S_PK_CMP;
      S_PK_CMP:   state_next = S_DONE;
      S_RHS:      state_next = S_SCAN_RD;
      S_SCAN_RD:  state_next = S_SCAN_LAT;
      S_SCAN_LAT: state_next = S_MUL;
      S_CMP:      state_next = (lhs_wins || scan_last) ? S_DONE : S_SCAN_RD;
      S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Control outputs toward the port, the multiplier and the tables.
  always_comb begin
    in_stall        = (state != S_IDLE);
    mac_ctrl.mul_en = (state == S_MUL);
    mac_ctrl.a      = pick(uop.src_a, dur_q, record_count, square_total,
                           length_total, cand_peak, p2, n2);
    mac_ctrl.b      = pick(uop.src_b, dur_q, record_count, square_total,
                           length_total, cand_peak, p2, n2);
    mac_ctrl.shift  = uop.shift;
    mac_ctrl.acc_op = (state == S_ACC) ? uop.acc_op : ACC_HOLD;
    ram_we_key      = (state == S_NEW_WR);
    ram_we_peak     = (state == S_NEW_WR) ||
                      ((state == S_PK_CMP) && (dur_q > peak_rdata));
    unique case (state)
      S_SRCH:    ram_addr = srch_idx[ADDR_W-1:0];
      S_SCAN_RD: ram_addr = report_cursor[ADDR_W-1:0];
      default:   ram_addr = slot[ADDR_W-1:0];
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Totals, table bookkeeping and fault.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count     <= '0;
      record_count  <= '0;
      length_total  <= '0;
      square_total  <= '0;
      report_cursor <= '0;
      fault         <= FAULT_NONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (do_clear) begin
              key_count     <= '0;
              record_count  <= '0;
              length_total  <= '0;
              square_total  <= '0;
              report_cursor <= '0;
              fault         <= FAULT_NONE;
            end
            if (fault_eff == FAULT_NONE) begin
              if (operation == OP_ADD) begin
                if (rec_full) begin
                  fault <= FAULT_SESSIONS;
                end
              end else if (report_cursor >= key_count) begin
                report_cursor <= key_count;
              end
            end
          end
        end
        S_SRCH: begin
          if (!srch_hit && !srch_more && (key_count == UCNT_W'(MAX_USERS))) begin
            fault <= FAULT_USERS;
          end
        end
        S_ACC: begin
          if (step == STEP_SQUARE) begin
            square_total  <= square_total + SQ_W'(prod);
            length_total  <= length_total + SUM_W'(dur_q);
            record_count  <= record_count + 1'b1;
            report_cursor <= '0;
          end
        end
        S_NEW_WR: key_count <= key_count + 1'b1;
        S_CMP:    report_cursor <= report_cursor + 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            op_q      <= operation;
            uid_q     <= user_id;
            dur_q     <= end_time - start_time;
            srch_idx  <= '0;
            cmp_valid <= 1'b0;
            step      <= STEP_N2;
            res_user  <= '0;
            res_peak  <= '0;
            if (fault_eff != FAULT_NONE) begin
              res_status <= fault_status(fault_eff);
            end else if (operation == OP_ADD) begin
              res_status <= rec_full ? STAT_TOO_MANY_SESS : STAT_ACCEPTED;
            end else begin
              res_status <= STAT_NO_MORE;
            end
          end
        end
        S_SRCH: begin
          if (srch_hit) begin
            slot   <= cmp_idx;
            is_new <= 1'b0;
            step   <= STEP_SQUARE;
          end else if (!srch_more) begin
            slot   <= key_count;
            is_new <= 1'b1;
            step   <= STEP_SQUARE;
            if (key_count == UCNT_W'(MAX_USERS)) begin
              res_status <= STAT_TOO_MANY_USERS;
            end
          end else begin
            srch_idx  <= srch_idx + 1'b1;
            cmp_valid <= 1'b1;
            cmp_idx   <= srch_idx;
          end
        end
        S_ACC: begin
          if (step == STEP_N2) begin
            n2 <= prod[31:0];
          end
          if (step == STEP_P2) begin
            p2 <= prod;
          end
          step <= 4'(step + 1'b1);
        end
        S_RHS: rhs <= acc;
        S_SCAN_LAT: begin
          cand_key  <= key_rdata;
          cand_peak <= peak_rdata;
          step      <= STEP_P2;
        end
        S_CMP: begin
          if (lhs_wins) begin
            res_status <= STAT_REPORTED;
            res_user   <= cand_key;
            res_peak   <= cand_peak;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: loaded from the staged result, drained by the sink.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid    <= 1'b1;
      status       <= res_status;
      report_user  <= res_user;
      max_duration <= res_peak;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // The work register op_q records the kind of request for the first assertion below.
  `PKVF_NEVER(a_fetch_no_search, (state == S_SRCH) && (op_q == OP_FETCH), "fetch in search")
  `PKVF_CHECK(a_users_bound, key_count <= UCNT_W'(MAX_USERS), "user count over limit")
  `PKVF_CHECK(a_cursor_bound, report_cursor <= key_count, "cursor beyond user count")
  `PKVF_NEVER(a_sess_bound, record_count > SCNT_W'(MAX_SESSIONS), "session count over limit")
  `PKVF_CHECK(a_fault_sticky, (fault != FAULT_NONE) && (state != S_IDLE) |=> fault == $past(fault), "fault changed while busy")

endmodule
